>>> rtl/core/stbs_pkg.sv
package stbs_pkg;

  localparam int unsigned TableDepthDef = 1024;
  localparam int unsigned IdxW          = 10;
  localparam int unsigned ValW          = 32;
  localparam int unsigned LenW          = 11;

  localparam logic OpWrite  = 1'b0;
  localparam logic OpSearch = 1'b1;

endpackage

>>> rtl/core/sorted_table_binary_search_core.sv
// Sorted table with binary search. A write item (op = write) stores one signed
// entry at entry_index and, with last_entry set, makes the table length
// entry_index + 1; writes at or beyond TABLE_DEPTH are dropped whole and give
// no result. A search item gives one result: found and the position of the
// first probed entry equal to target, or found = 0 and position = 0. A search
// issues the first table read at setup, then probes one midpoint at a time,
// at most ceil(log2(length + 1)) probes (11 for a full 1024-entry table),
// before the result goes to the output register. The block takes no new item
// while a search runs: each probe is one read of the single table port
// followed by one compare that picks the next midpoint. Writes are taken while
// an earlier result still waits on the output.
module sorted_table_binary_search_core #(
  parameter int unsigned TABLE_DEPTH = stbs_pkg::TableDepthDef
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic                       op_i,
  input  logic [stbs_pkg::IdxW-1:0]  entry_index_i,
  input  logic signed [stbs_pkg::ValW-1:0] entry_value_i,
  input  logic                       last_entry_i,
  input  logic signed [stbs_pkg::ValW-1:0] target_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic                       found_o,
  output logic [stbs_pkg::IdxW-1:0]  position_o
);
  import stbs_pkg::*;

  localparam int unsigned AW = $clog2(TABLE_DEPTH);

  typedef enum logic [2:0] {
    StIdle  = 3'b001,
    StProbe = 3'b010,
    StHold  = 3'b100
  } state_e;

  state_e state_q, state_d;

  logic signed [ValW-1:0] mem [TABLE_DEPTH];
  logic signed [ValW-1:0] rd_data_q;
  logic signed [ValW-1:0] target_q;

  logic [LenW-1:0] len_q, len_d;
  logic [LenW-1:0] lo_q, lo_d, hi_q, hi_d, mid_q, mid_d;
  logic            out_valid_q, out_valid_d;
  logic            found_q, found_d;
  logic [IdxW-1:0] pos_q, pos_d;
  logic            res_found_q, res_found_d;
  logic [IdxW-1:0] res_pos_q, res_pos_d;

  logic            in_acc, wr_acc, srch_acc, wr_ok;
  logic            out_free, rd_en;
  logic            lt, eq;
  logic [LenW-1:0] lo_s, hi_s, mid_s;
  logic            more;
  logic [31:0]     wr_idx_ext, mid_ext;
  logic [AW-1:0]   wr_addr, rd_addr;

  assign in_ready_o = (state_q == StIdle);
  assign in_acc     = in_valid_i && in_ready_o;
  assign wr_acc     = in_acc && (op_i == OpWrite);
  assign srch_acc   = in_acc && (op_i == OpSearch);
  assign wr_ok      = 32'(entry_index_i) < 32'(TABLE_DEPTH);
  assign wr_idx_ext = 32'(entry_index_i);
  assign wr_addr    = wr_idx_ext[AW-1:0];
  assign out_free   = !out_valid_q || out_ready_i;

  assign eq = (rd_data_q == target_q);
  assign lt = (rd_data_q < target_q);

  // Shared midpoint unit: bounds come from the table length at setup,
  // from the compare result while probing. hi is exclusive.
  always_comb begin
    if (state_q == StIdle) begin
      lo_s = '0;
      hi_s = len_q;
    end else if (lt) begin
      lo_s = mid_q + LenW'(1);
      hi_s = hi_q;
    end else begin
      lo_s = lo_q;
      hi_s = mid_q;
    end
    more  = lo_s < hi_s;
    mid_s = lo_s + ((hi_s - LenW'(1) - lo_s) >> 1);
  end

  assign mid_ext = 32'(mid_s);
  assign rd_addr = mid_ext[AW-1:0];

  always_comb begin
    state_d     = state_q;
    len_d       = len_q;
    lo_d        = lo_q;
    hi_d        = hi_q;
    mid_d       = mid_q;
    out_valid_d = out_valid_q && !out_ready_i;
    found_d     = found_q;
    pos_d       = pos_q;
    res_found_d = res_found_q;
    res_pos_d   = res_pos_q;
    rd_en       = 1'b0;

    case (state_q)
      StIdle: begin
        if (wr_acc && wr_ok && last_entry_i) begin
          len_d = LenW'(entry_index_i) + LenW'(1);
        end
        if (srch_acc) begin
          if (more) begin
            lo_d    = lo_s;
            hi_d    = hi_s;
            mid_d   = mid_s;
            rd_en   = 1'b1;
            state_d = StProbe;
          end else if (out_free) begin
            out_valid_d = 1'b1;
            found_d     = 1'b0;
            pos_d       = '0;
          end else begin
            res_found_d = 1'b0;
            res_pos_d   = '0;
            state_d     = StHold;
          end
        end
      end
      StProbe: begin
        if (eq || !more) begin
          res_found_d = eq;
          res_pos_d   = eq ? mid_q[IdxW-1:0] : '0;
          if (out_free) begin
            out_valid_d = 1'b1;
            found_d     = res_found_d;
            pos_d       = res_pos_d;
            state_d     = StIdle;
          end else begin
            state_d = StHold;
          end
        end else begin
          lo_d  = lo_s;
          hi_d  = hi_s;
          mid_d = mid_s;
          rd_en = 1'b1;
        end
      end
      StHold: begin
        // wait for the output register to drain
        if (out_free) begin
          out_valid_d = 1'b1;
          found_d     = res_found_q;
          pos_d       = res_pos_q;
          state_d     = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      len_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      len_q       <= len_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    lo_q        <= lo_d;
    hi_q        <= hi_d;
    mid_q       <= mid_d;
    found_q     <= found_d;
    pos_q       <= pos_d;
    res_found_q <= res_found_d;
    res_pos_q   <= res_pos_d;
    if (srch_acc) begin
      target_q <= target_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_acc && wr_ok) begin
      mem[wr_addr] <= entry_value_i;
    end
    if (rd_en) begin
      rd_data_q <= mem[rd_addr];
    end
  end

  assign out_valid_o = out_valid_q;
  assign found_o     = found_q;
  assign position_o  = pos_q;

endmodule

>>> rtl/core/stbs_checker.sv
module stbs_checker (
  input logic                      clk_i,
  input logic                      rst_ni,
  input logic                      in_valid_i,
  input logic                      in_ready_o,
  input logic                      op_i,
  input logic                      out_valid_o,
  input logic                      out_ready_i,
  input logic                      found_o,
  input logic [stbs_pkg::IdxW-1:0] position_o
);
  import stbs_pkg::*;

  // stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(found_o) && $stable(position_o))
    else $error("result changed while stalled");

  a_miss_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !found_o |-> position_o == '0)
    else $error("miss with nonzero position");

  // a write item never creates a result
  a_write_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && (op_i == OpWrite) && !out_valid_o |=> !out_valid_o)
    else $error("write item produced a result");

  // a write item leaves the input side ready for the next item
  a_write_one_cycle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && (op_i == OpWrite) |=> in_ready_o)
    else $error("write item held the input side");

endmodule

bind sorted_table_binary_search_core stbs_checker u_stbs_checker (.*);

>>> dv/tb.sv
module tb;

  localparam int Depth      = stbs_pkg::TableDepthDef;
  localparam int CycleLimit = 300000;
  localparam int ItemGoal   = 1850;

  localparam logic signed [stbs_pkg::ValW-1:0] MinVal = 32'sh8000_0000;
  localparam logic signed [stbs_pkg::ValW-1:0] MaxVal = 32'sh7fff_ffff;

  typedef struct packed {
    logic                      found;
    logic [stbs_pkg::IdxW-1:0] position;
  } hit_t;

  // Shadow of the table plus the search results still owed by the block.
  class search_checker;
    logic signed [stbs_pkg::ValW-1:0] entries [Depth];
    int unsigned length;
    hit_t        hits_due [$];
    int unsigned errors;
    int unsigned hits_checked;

    function new();
      foreach (entries[i]) entries[i] = '0;
      length       = 0;
      errors       = 0;
      hits_checked = 0;
    endfunction

    function hit_t lookup(logic signed [stbs_pkg::ValW-1:0] tgt);
      hit_t res;
      int   lo;
      int   hi;
      int   mid;
      res = '0;
      lo  = 0;
      hi  = int'(length) - 1;
      while (lo <= hi) begin
        mid = lo + (hi - lo) / 2;
        if (entries[mid] == tgt) begin
          res.found    = 1'b1;
          res.position = mid[stbs_pkg::IdxW-1:0];
          return res;
        end
        if (entries[mid] < tgt) lo = mid + 1;
        else hi = mid - 1;
      end
      return res;
    endfunction

    function void note_item(logic op, logic [stbs_pkg::IdxW-1:0] idx,
                            logic signed [stbs_pkg::ValW-1:0] val, logic last,
                            logic signed [stbs_pkg::ValW-1:0] tgt);
      if (op == stbs_pkg::OpWrite) begin
        if (idx < Depth) begin
          entries[idx] = val;
          if (last) length = idx + 1;
        end
      end else begin
        hits_due.insert(hits_due.size(), lookup(tgt));
      end
    endfunction

    task report(string msg);
      $display("tb: mismatch at %0t: %s", $time, msg);
      errors++;
    endtask

    task check_hit(logic found, logic [stbs_pkg::IdxW-1:0] position);
      hit_t want;
      if (hits_due.size() == 0) begin
        report("result with no search outstanding");
      end else begin
        want = hits_due.pop_front();
        hits_checked++;
        if (found !== want.found)
          report($sformatf("found %b, want %b", found, want.found));
        if (position !== want.position)
          report($sformatf("position %0d, want %0d", position, want.position));
      end
    endtask
  endclass

  logic                             clk_i = 1'b0;
  logic                             rst_ni;
  logic                             in_valid_i;
  logic                             in_ready_o;
  logic                             op_i;
  logic [stbs_pkg::IdxW-1:0]        entry_index_i;
  logic signed [stbs_pkg::ValW-1:0] entry_value_i;
  logic                             last_entry_i;
  logic signed [stbs_pkg::ValW-1:0] target_i;
  logic                             out_valid_o;
  logic                             out_ready_i;
  logic                             found_o;
  logic [stbs_pkg::IdxW-1:0]        position_o;

  sorted_table_binary_search_core uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .op_i          (op_i),
    .entry_index_i (entry_index_i),
    .entry_value_i (entry_value_i),
    .last_entry_i  (last_entry_i),
    .target_i      (target_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .found_o       (found_o),
    .position_o    (position_o)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  search_checker searches = new();

  // Generator view of the table: which entries hold data and what was planned.
  bit                               filled  [Depth];
  logic signed [stbs_pkg::ValW-1:0] planned [Depth];
  int                               filled_run;
  int                               table_len;
  int                               items_sent;
  int                               cycles;
  bit                               src_idle;
  bit                               snk_idle;

  always @(posedge clk_i) begin
    cycles++;
    if (cycles == CycleLimit) begin
      $display("tb: timeout after %0d cycles", cycles);
      $display("tb: FAIL");
      $finish;
    end
  end

  task automatic send_item(logic op, logic [stbs_pkg::IdxW-1:0] idx,
                           logic signed [stbs_pkg::ValW-1:0] val, logic last,
                           logic signed [stbs_pkg::ValW-1:0] tgt);
    int gap;
    gap = src_idle ? $urandom_range(0, 10) : 0;
    if (gap != 0) begin
      in_valid_i = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    op_i          = op;
    entry_index_i = idx;
    entry_value_i = val;
    last_entry_i  = last;
    target_i      = tgt;
    in_valid_i    = 1'b1;
    do @(posedge clk_i); while (!in_ready_o);
    searches.note_item(op, idx, val, last, tgt);
    items_sent++;
    @(negedge clk_i);
  endtask

  // Close the table only when every entry below the new length holds data.
  task automatic write_entry(int idx, logic signed [stbs_pkg::ValW-1:0] val, bit last);
    bit close;
    filled[idx]  = 1'b1;
    planned[idx] = val;
    while (filled_run < Depth && filled[filled_run]) filled_run++;
    close = last && (idx < filled_run);
    if (close) table_len = idx + 1;
    send_item(stbs_pkg::OpWrite, 10'(idx), val, close, $signed($urandom));
  endtask

  task automatic search_for(logic signed [stbs_pkg::ValW-1:0] tgt);
    send_item(stbs_pkg::OpSearch, 10'($urandom), $signed($urandom),
              1'($urandom), tgt);
  endtask

  function automatic logic signed [stbs_pkg::ValW-1:0] pick_target();
    logic signed [stbs_pkg::ValW-1:0] tgt;
    int                               k;
    k   = $urandom_range(0, 9);
    tgt = $signed($urandom);
    case (k)
      0, 1, 2, 3, 4: if (table_len > 0) tgt = planned[$urandom_range(0, table_len - 1)];
      5:             if (table_len > 0) tgt = planned[$urandom_range(0, table_len - 1)] + 1;
      6:             if (table_len > 0) tgt = planned[$urandom_range(0, table_len - 1)] - 1;
      7:             tgt = MinVal;
      8:             tgt = MaxVal;
      default: ;
    endcase
    return tgt;
  endfunction

  // Fill positions 0..len-1 in ascending order; spacing depends on the mode.
  task automatic build_table(int len);
    longint v;
    longint step;
    int     mode;
    bit     last;
    mode = $urandom_range(0, 2);
    case (mode)
      0:       v = longint'($signed($urandom));
      1:       v = longint'($signed($urandom)) >>> 1;
      default: v = -64'sd2147483648;
    endcase
    for (int i = 0; i < len; i++) begin
      if (v > 64'sd2147483647) v = 64'sd2147483647;
      if (mode == 2 && i == len - 1 && len > 1) v = 64'sd2147483647;
      last = (i == len - 1) || ($urandom_range(0, 7) == 0);
      write_entry(i, v[31:0], last);
      case (mode)
        0:       step = $urandom_range(0, 2);
        1:       step = $urandom_range(1, 1000);
        default: step = 64'd4294967295 / len;
      endcase
      v = v + step;
    end
  endtask

  // Searches with the odd stray write that may unsort, shorten or grow the table.
  task automatic search_burst(int count);
    int idx;
    int span;
    for (int n = 0; n < count; n++) begin
      if ($urandom_range(0, 7) == 0) begin
        span = (table_len + 4 < Depth) ? table_len + 4 : Depth - 1;
        idx  = $urandom_range(0, span);
        write_entry(idx, $signed($urandom), $urandom_range(0, 3) == 0);
      end
      search_for(pick_target());
    end
  endtask

  initial begin
    int gap;
    int got;
    got         = 0;
    out_ready_i = 1'b0;
    @(posedge rst_ni);
    @(negedge clk_i);
    forever begin
      gap = snk_idle ? $urandom_range(0, 10) : 0;
      // Hold off long enough for the block to back up into its input.
      if (got == 40 || got == 200) gap = gap + 400;
      if (gap != 0) begin
        out_ready_i = 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      out_ready_i = 1'b1;
      do @(posedge clk_i); while (!out_valid_o);
      searches.check_hit(found_o, position_o);
      got++;
      @(negedge clk_i);
    end
  end

  initial begin
    logic signed [stbs_pkg::ValW-1:0] dir_vals [8];
    int                               len;
    dir_vals = '{MinVal, -32'sd1000, -32'sd1, 32'sd0, 32'sd1, 32'sd5, 32'sd1000, MaxVal};
    rst_ni        = 1'b0;
    in_valid_i    = 1'b0;
    op_i          = stbs_pkg::OpWrite;
    entry_index_i = '0;
    entry_value_i = '0;
    last_entry_i  = 1'b0;
    target_i      = '0;
    filled_run    = 0;
    table_len     = 0;
    items_sent    = 0;
    cycles        = 0;
    src_idle      = 1'b0;
    snk_idle      = 1'b0;
    repeat (6) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Directed: empty table, value extremes, shortened length, top index.
    search_for(32'sd0);
    for (int i = 0; i < 8; i++) write_entry(i, dir_vals[i], i == 7);
    search_for(MinVal);
    search_for(MaxVal);
    search_for(-32'sd1);
    search_for(32'sd0);
    search_for(32'sd2);
    search_for(MinVal + 1);
    write_entry(3, 32'sd0, 1'b1);
    search_for(MaxVal);
    search_for(32'sd1);
    search_for(-32'sd1000);
    write_entry(Depth - 1, MaxVal, 1'b0);
    write_entry(7, MaxVal, 1'b1);
    search_for(MaxVal);

    // Full-depth table once, for the longest searches.
    src_idle = 1'b1;
    snk_idle = 1'b1;
    build_table(Depth);
    search_burst(120);

    // Mostly short tables, now and then a longer one.
    while (items_sent < ItemGoal) begin
      src_idle = ($urandom_range(0, 3) != 0);
      snk_idle = ($urandom_range(0, 3) != 0);
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(25, 200) : $urandom_range(1, 24);
      build_table(len);
      search_burst($urandom_range(5, 20));
    end
    in_valid_i = 1'b0;

    while (searches.hits_due.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);

    $display("tb: %0d items driven, %0d search results checked, %0d mismatches",
             items_sent, searches.hits_checked, searches.errors);
    $display("tb: tables from empty to full depth, stray writes, two long output stalls");
    if (searches.errors == 0) $display("tb: PASS");
    else $display("tb: FAIL");
    $finish;
  end

endmodule

>>> filelist.f
rtl/core/stbs_pkg.sv
rtl/core/sorted_table_binary_search_core.sv
rtl/core/stbs_checker.sv
dv/tb.sv
